>>> hdl/spq_pkg.sv
// sorted priority queue: shared package
// action, status and sequencer state codes plus the sequencer control struct
// no dependencies
package spq_pkg;

    localparam int TOTAL_BITS  = 5;
    localparam int ACTION_BITS = 2;
    localparam int STATUS_BITS = 2;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_PEEK    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_READ,
        S_EVAL,
        S_WRNEW
    } seq_state_t;

    // strobes from the sequencer to the slot store and result registers
    typedef struct packed {
        logic    rd_en;
        logic    wr_en;
        logic    wr_new;
        logic    take_head;
        logic    finish;
        status_t status;
    } seq_ctl_t;

endpackage

>>> hdl/sorted_priority_queue.sv
// sorted priority queue: top level
// request capture, write data select and result registers around the store and sequencer
// depends on spq_pkg, spq_store, spq_seq
//
//  channel   | handshake            | fields
//  ----------+----------------------+-----------------------------------------------
//  request   | start, busy          | action, item_key, item_payload
//  result    | done (one-cycle)     | status, head_key, head_payload, entry_total,
//            |                      | is_empty
//
// a request needs no slot walk when refused, on an empty queue or as the first entry
// peek reads the head slot only; enqueue walks up from the tail, moving down each entry
// the new one goes ahead of, with a separate write when it lands at the head; dequeue
// reads every entry held and moves each up one place; the walk is set by the single
// slot memory port pair: one read then one compare/write per slot; reset clears the
// sequencer, entry count, done, status, entry total and is_empty, but not the head
// fields or slot contents; done is a registered pulse and cannot be held off by the receiver
module sorted_priority_queue #(
    parameter int DEPTH        = 16,
    parameter int KEY_BITS     = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [spq_pkg::ACTION_BITS-1:0]     action,
    input  logic [KEY_BITS-1:0]                 item_key,
    input  logic [PAYLOAD_BITS-1:0]             item_payload,
    output logic                                done,
    output logic [spq_pkg::STATUS_BITS-1:0]     status,
    output logic [KEY_BITS-1:0]                 head_key,
    output logic [PAYLOAD_BITS-1:0]             head_payload,
    output logic [spq_pkg::TOTAL_BITS-1:0]      entry_total,
    output logic                                is_empty
);
    import spq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                    accept;
    seq_ctl_t                ctl;
    logic [IW-1:0]           rd_addr, wr_addr;
    logic [CW-1:0]           count_upd;
    logic [KEY_BITS-1:0]     rd_key;
    logic [PAYLOAD_BITS-1:0] rd_payload;
    logic [KEY_BITS-1:0]     wr_key;
    logic [PAYLOAD_BITS-1:0] wr_payload;

    // captured request
    logic [KEY_BITS-1:0]     key_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;

    // result registers
    logic                    done_reg;
    status_t                 status_reg;
    logic [KEY_BITS-1:0]     head_key_reg;
    logic [PAYLOAD_BITS-1:0] head_payload_reg;
    logic [TOTAL_BITS-1:0]   total_reg;
    logic                    empty_reg;

    assign accept = start && !busy;

    spq_seq #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .act       (action_t'(action)),
        .new_key   (key_reg),
        .rd_key    (rd_key),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .count_upd (count_upd),
        .busy      (busy)
    );

    // new entry or the slot just read, moved by one place
    assign wr_key     = ctl.wr_new ? key_reg     : rd_key;
    assign wr_payload = ctl.wr_new ? payload_reg : rd_payload;

    spq_store #(
        .DEPTH        (DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_store (
        .clk        (clk),
        .wr_en      (ctl.wr_en),
        .wr_addr    (wr_addr),
        .wr_key     (wr_key),
        .wr_payload (wr_payload),
        .rd_en      (ctl.rd_en),
        .rd_addr    (rd_addr),
        .rd_key     (rd_key),
        .rd_payload (rd_payload)
    );

    // request payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg     <= item_key;
            payload_reg <= item_payload;
        end
    end

    // head fields: cleared per request, loaded when the head slot is read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_key_reg     <= '0;
            head_payload_reg <= '0;
        end
        else if (ctl.take_head)
        begin
            head_key_reg     <= rd_key;
            head_payload_reg <= rd_payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            total_reg  <= '0;
            empty_reg  <= 1'b1;
        end
        else
        begin
            done_reg <= ctl.finish;
            if (ctl.finish)
            begin
                status_reg <= ctl.status;
                // count after the request, held to the field width
                total_reg  <= TOTAL_BITS'(count_upd);
                empty_reg  <= (count_upd == '0);
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign head_key     = head_key_reg;
    assign head_payload = head_payload_reg;
    assign entry_total  = total_reg;
    assign is_empty     = empty_reg;

endmodule

>>> hdl/spq_store.sv
// sorted priority queue: slot memory
// one write port, one read port with registered read data
// depends on nothing
module spq_store #(
    parameter int DEPTH        = 16,
    parameter int KEY_BITS     = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [KEY_BITS-1:0]         wr_key,
    input  logic [PAYLOAD_BITS-1:0]     wr_payload,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [KEY_BITS-1:0]         rd_key,
    output logic [PAYLOAD_BITS-1:0]     rd_payload
);

    logic [KEY_BITS-1:0]     key_mem [DEPTH];
    logic [PAYLOAD_BITS-1:0] pay_mem [DEPTH];
    logic [KEY_BITS-1:0]     rd_key_reg;
    logic [PAYLOAD_BITS-1:0] rd_payload_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            pay_mem[wr_addr] <= wr_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg     <= key_mem[rd_addr];
            rd_payload_reg <= pay_mem[rd_addr];
        end
    end

    assign rd_key     = rd_key_reg;
    assign rd_payload = rd_payload_reg;

endmodule

>>> hdl/spq_seq.sv
// sorted priority queue: sequencer with the shared key comparator
// walks the slots one per read/compare pair, owns the entry count
// depends on spq_pkg
module spq_seq #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  spq_pkg::action_t              act,
    input  logic [KEY_BITS-1:0]           new_key,
    input  logic [KEY_BITS-1:0]           rd_key,
    output spq_pkg::seq_ctl_t             ctl,
    output logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [$clog2(DEPTH)-1:0]      wr_addr,
    output logic [$clog2(DEPTH+1)-1:0]    count_upd,
    output logic                          busy
);
    import spq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    seq_state_t      state_reg, state_next;
    action_t         act_reg;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [IW-1:0]   last_idx;
    logic            key_lt, key_eq, shift_down;

    // shared comparator: stored key against new key
    assign key_lt = rd_key < new_key;
    assign key_eq = rd_key == new_key;
    // an equal key at the head stays first, elsewhere the new entry goes ahead
    assign shift_down = (idx_reg == '0) ? key_lt : (key_lt || key_eq);

    assign last_idx = IW'(count_reg - CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg   <= ACT_NONE;
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (start && state_reg == S_IDLE)
            begin
                act_reg <= act;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        ctl        = '0;
        ctl.status = ST_OK;
        rd_addr    = idx_reg;
        wr_addr    = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_PLAN;
                end
            end

            S_PLAN:
            begin
                unique case (act_reg) inside
                    ACT_ENQUEUE:
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            ctl.finish = 1'b1;
                            ctl.status = ST_FULL;
                            state_next = S_IDLE;
                        end
                        else if (count_reg == '0)
                        begin
                            ctl.wr_en  = 1'b1;
                            ctl.wr_new = 1'b1;
                            wr_addr    = '0;
                            count_next = count_reg + CW'(1);
                            ctl.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = last_idx;
                            state_next = S_READ;
                        end
                    end
                    ACT_DEQUEUE, ACT_PEEK:
                    begin
                        if (count_reg == '0)
                        begin
                            ctl.finish = 1'b1;
                            ctl.status = ST_EMPTY;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        ctl.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_READ:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                unique case (act_reg) inside
                    ACT_ENQUEUE:
                    begin
                        ctl.wr_en = 1'b1;
                        wr_addr   = idx_reg + IW'(1);
                        if (shift_down)
                        begin
                            if (idx_reg == '0)
                            begin
                                state_next = S_WRNEW;
                            end
                            else
                            begin
                                idx_next   = idx_reg - IW'(1);
                                state_next = S_READ;
                            end
                        end
                        else
                        begin
                            ctl.wr_new = 1'b1;
                            count_next = count_reg + CW'(1);
                            ctl.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    ACT_DEQUEUE:
                    begin
                        if (idx_reg == '0)
                        begin
                            ctl.take_head = 1'b1;
                        end
                        else
                        begin
                            ctl.wr_en = 1'b1;
                            wr_addr   = idx_reg - IW'(1);
                        end
                        if (idx_reg == last_idx)
                        begin
                            count_next = count_reg - CW'(1);
                            ctl.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IW'(1);
                            state_next = S_READ;
                        end
                    end
                    ACT_PEEK:
                    begin
                        ctl.take_head = 1'b1;
                        ctl.finish    = 1'b1;
                        state_next    = S_IDLE;
                    end
                    default:
                    begin
                        ctl.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_WRNEW:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_new = 1'b1;
                wr_addr    = '0;
                count_next = count_reg + CW'(1);
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign count_upd = count_next;
    assign busy      = (state_reg != S_IDLE);

endmodule
